@@ rtl/core/rwhp_pkg.sv @@
package rwhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [23:0] TAG_FMT3 = 24'h74_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_BODY = 32'd16;
  localparam logic [31:0] START_COUNT = 32'd8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_FIELDS_W = 164;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    PHASE_RIFF  = 4'd0,
    PHASE_RSIZE = 4'd1,
    PHASE_WAVE  = 4'd2,
    PHASE_ID    = 4'd3,
    PHASE_FSIZE = 4'd4,
    PHASE_DSIZE = 4'd5,
    PHASE_OSIZE = 4'd6,
    PHASE_TAG   = 4'd7,
    PHASE_CH    = 4'd8,
    PHASE_RATE  = 4'd9,
    PHASE_BRATE = 4'd10,
    PHASE_ALIGN = 4'd11,
    PHASE_BITS  = 4'd12,
    PHASE_SKIP  = 4'd13,
    PHASE_PAD   = 4'd14
  } phase_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOT_RIFF = 2'd1,
    STATUS_NOT_WAVE = 2'd2,
    STATUS_NO_DATA  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FORMAT_MONO8    = 2'd0,
    FORMAT_MONO16   = 2'd1,
    FORMAT_STEREO8  = 2'd2,
    FORMAT_STEREO16 = 2'd3
  } format_e;

  // one classified header result travelling from the parser to the output stage
  typedef struct packed {
    status_e     status;
    logic [15:0] compression;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } result_t;

endpackage

@@ rtl/core/riff_wave_header_parser.sv @@
// Channel  Dir  Port group   tdata fields (low bit up)                     tuser / tlast
// input    in   s_axis_*     data_byte[7:0]                                first_byte / last_byte
// result   out  m_axis_*     status, format_code, compression, channels,   - / -
//                            sample_rate, byte_rate, block_align,
//                            bits_per_sample, data_size, zero fill
// One byte is taken every cycle unless the result queue is full; each byte steps the parser's state once.
// A result passes from the parser into the queue, then from the queue into the output register.
// The input stalls only when the result queue is full; the output stalls independently.
// Reset (rst_ni low, asynchronous) puts the parser at the start of a file.
module riff_wave_header_parser #(
  parameter int unsigned QueueDepth = rwhp_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rwhp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // data_byte[7:0]
  input  logic                                s_axis_tuser,   // first_byte
  input  logic                                s_axis_tlast,   // last_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status[1:0], format_code[3:2], compression[19:4], channels[35:20],
  // sample_rate[67:36], byte_rate[99:68], block_align[115:100],
  // bits_per_sample[131:116], data_size[163:132], zero[167:164]
  output logic [rwhp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import rwhp_pkg::*;

  logic    push, full, q_valid, pop;
  result_t push_entry, q_entry;

  rwhp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .first_byte_i (s_axis_tuser),
    .last_byte_i  (s_axis_tlast),
    .queue_full_i (full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  rwhp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  rwhp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (q_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ rtl/core/rwhp_front.sv @@
module rwhp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_byte_i,
  input  logic                  last_byte_i,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output rwhp_pkg::result_t     entry_o
);
  import rwhp_pkg::*;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  phase_e      phase_q, phase_d, c_phase;
  logic [1:0]  cnt_q, cnt_d, c_cnt;
  logic [23:0] shift_q, shift_d, c_shift;
  logic [31:0] riff_q, riff_d, c_riff;
  logic [31:0] consumed_q, consumed_d, c_consumed;
  logic [31:0] len_q, len_d, c_len;
  logic [31:0] skip_q, skip_d, c_skip;
  logic [15:0] tag_q, tag_d, c_tag;
  logic [15:0] chan_q, chan_d, c_chan;
  logic [31:0] rate_q, rate_d, c_rate;
  logic [31:0] brate_q, brate_d, c_brate;
  logic [15:0] align_q, align_d, c_align;
  logic [15:0] bits_q, bits_d, c_bits;
  logic        pad_q, pad_d, c_pad;
  logic        done_q, done_d, c_done;

  logic        accept;
  logic        need4, fdone;
  logic [31:0] word;
  logic [15:0] half;
  logic [31:0] body_len;
  logic [31:0] pad_count;
  logic        res_valid;
  status_e     res_status;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !queue_full_i;

  // a first byte restarts parsing before its own byte is looked at
  always_comb begin
    if (first_byte_i) begin
      c_phase = PHASE_RIFF;  c_cnt = '0;       c_shift = '0;
      c_riff = '0;           c_consumed = START_COUNT;
      c_len = '0;            c_skip = '0;
      c_tag = '0;            c_chan = '0;      c_rate = '0;
      c_brate = '0;          c_align = '0;     c_bits = '0;
      c_pad = 1'b0;          c_done = 1'b0;
    end else begin
      c_phase = phase_q;     c_cnt = cnt_q;    c_shift = shift_q;
      c_riff = riff_q;       c_consumed = consumed_q;
      c_len = len_q;         c_skip = skip_q;
      c_tag = tag_q;         c_chan = chan_q;  c_rate = rate_q;
      c_brate = brate_q;     c_align = align_q; c_bits = bits_q;
      c_pad = pad_q;         c_done = done_q;
    end
  end

  assign need4     = !(c_phase == PHASE_TAG || c_phase == PHASE_CH ||
                       c_phase == PHASE_ALIGN || c_phase == PHASE_BITS);
  assign fdone     = need4 ? (c_cnt == 2'd3) : (c_cnt == 2'd1);
  assign word      = {data_byte_i, c_shift};
  assign half      = {data_byte_i, c_shift[7:0]};
  assign body_len  = (c_len > FMT_BODY) ? c_len : FMT_BODY;
  assign pad_count = sat_add(c_consumed, 32'd1);

  // next state of the parser for one byte
  always_comb begin
    phase_d = c_phase;     cnt_d = c_cnt;    shift_d = c_shift;
    riff_d = c_riff;       consumed_d = c_consumed;
    len_d = c_len;         skip_d = c_skip;
    tag_d = c_tag;         chan_d = c_chan;  rate_d = c_rate;
    brate_d = c_brate;     align_d = c_align; bits_d = c_bits;
    pad_d = c_pad;         done_d = c_done;
    res_valid = 1'b0;
    res_status = STATUS_OK;

    if (!c_done) begin
      if (c_phase != PHASE_SKIP && c_phase != PHASE_PAD) begin
        if (fdone) begin
          shift_d = '0;
          cnt_d   = '0;
        end else begin
          shift_d = c_shift | (24'({16'd0, data_byte_i}) << {c_cnt, 3'd0});
          cnt_d   = c_cnt + 2'd1;
        end
      end

      case (c_phase)
        PHASE_RIFF: begin
          if (fdone) begin
            if (word != TAG_RIFF) begin
              res_valid = 1'b1;  res_status = STATUS_NOT_RIFF;
            end else begin
              phase_d = PHASE_RSIZE;
            end
          end
        end
        PHASE_RSIZE: begin
          if (fdone) begin
            riff_d  = word;
            phase_d = PHASE_WAVE;
          end
        end
        PHASE_WAVE: begin
          if (fdone) begin
            if (word != TAG_WAVE) begin
              res_valid = 1'b1;  res_status = STATUS_NOT_WAVE;
            end else if (c_consumed >= c_riff) begin
              res_valid = 1'b1;  res_status = STATUS_NO_DATA;
            end else begin
              phase_d = PHASE_ID;
            end
          end
        end
        PHASE_ID: begin
          if (fdone) begin
            // count the id and the size field that follows it together
            consumed_d = sat_add(c_consumed, 32'd8);
            if (word[23:0] == TAG_FMT3) begin
              phase_d = PHASE_FSIZE;
            end else if (word == TAG_DATA) begin
              phase_d = PHASE_DSIZE;
            end else begin
              phase_d = PHASE_OSIZE;
            end
          end
        end
        PHASE_FSIZE, PHASE_DSIZE, PHASE_OSIZE: begin
          if (fdone) begin
            len_d = word;
            pad_d = word[0];
            if (c_phase == PHASE_DSIZE) begin
              res_valid = 1'b1;  res_status = STATUS_OK;
            end else if (c_phase == PHASE_FSIZE) begin
              phase_d = PHASE_TAG;
            end else begin
              consumed_d = sat_add(c_consumed, word);
              skip_d     = word;
              if (word == '0) begin
                // empty chunk: even size, so no pad byte
                if (c_consumed >= c_riff) begin
                  res_valid = 1'b1;  res_status = STATUS_NO_DATA;
                end else begin
                  phase_d = PHASE_ID;
                end
              end else begin
                phase_d = PHASE_SKIP;
              end
            end
          end
        end
        PHASE_TAG: begin
          // charge the whole fmt body up front; it is not compared until its end
          if (c_cnt == 2'd0) begin
            consumed_d = sat_add(c_consumed, body_len);
          end
          if (fdone) begin
            tag_d   = half;
            phase_d = PHASE_CH;
          end
        end
        PHASE_CH: begin
          if (fdone) begin
            chan_d  = half;
            phase_d = PHASE_RATE;
          end
        end
        PHASE_RATE: begin
          if (fdone) begin
            rate_d  = word;
            phase_d = PHASE_BRATE;
          end
        end
        PHASE_BRATE: begin
          if (fdone) begin
            brate_d = word;
            phase_d = PHASE_ALIGN;
          end
        end
        PHASE_ALIGN: begin
          if (fdone) begin
            align_d = half;
            phase_d = PHASE_BITS;
          end
        end
        PHASE_BITS: begin
          if (fdone) begin
            bits_d = half;
            if (c_len > FMT_BODY) begin
              skip_d  = c_len - FMT_BODY;
              phase_d = PHASE_SKIP;
            end else begin
              skip_d = '0;
              if (c_pad) begin
                phase_d = PHASE_PAD;
              end else if (c_consumed >= c_riff) begin
                res_valid = 1'b1;  res_status = STATUS_NO_DATA;
              end else begin
                phase_d = PHASE_ID;
              end
            end
          end
        end
        PHASE_SKIP: begin
          skip_d = c_skip - 32'd1;
          if (c_skip == 32'd1) begin
            if (c_pad) begin
              phase_d = PHASE_PAD;
            end else if (c_consumed >= c_riff) begin
              res_valid = 1'b1;  res_status = STATUS_NO_DATA;
            end else begin
              phase_d = PHASE_ID;
            end
          end
        end
        PHASE_PAD: begin
          consumed_d = pad_count;
          pad_d      = 1'b0;
          if (pad_count >= c_riff) begin
            res_valid = 1'b1;  res_status = STATUS_NO_DATA;
          end else begin
            phase_d = PHASE_ID;
          end
        end
        default: begin
          res_valid = 1'b1;  res_status = STATUS_NO_DATA;
        end
      endcase

      // early end of file: report how far the header got
      if (!res_valid && last_byte_i) begin
        res_valid = 1'b1;
        if (phase_d == PHASE_RIFF) begin
          res_status = STATUS_NOT_RIFF;
        end else if (phase_d <= PHASE_WAVE) begin
          res_status = STATUS_NOT_WAVE;
        end else begin
          res_status = STATUS_NO_DATA;
        end
      end
      if (res_valid) begin
        done_d = 1'b1;
      end
    end
  end

  // result towards the queue
  always_comb begin
    push_o                 = accept && res_valid;
    entry_o.status         = res_status;
    entry_o.compression    = c_tag;
    entry_o.channels       = c_chan;
    entry_o.sample_rate    = c_rate;
    entry_o.byte_rate      = c_brate;
    entry_o.block_align    = c_align;
    entry_o.bits_per_sample = c_bits;
    entry_o.data_size      = word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PHASE_RIFF;
      cnt_q      <= '0;
      shift_q    <= '0;
      riff_q     <= '0;
      consumed_q <= START_COUNT;
      len_q      <= '0;
      skip_q     <= '0;
      tag_q      <= '0;
      chan_q     <= '0;
      rate_q     <= '0;
      brate_q    <= '0;
      align_q    <= '0;
      bits_q     <= '0;
      pad_q      <= 1'b0;
      done_q     <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      riff_q     <= riff_d;
      consumed_q <= consumed_d;
      len_q      <= len_d;
      skip_q     <= skip_d;
      tag_q      <= tag_d;
      chan_q     <= chan_d;
      rate_q     <= rate_d;
      brate_q    <= brate_d;
      align_q    <= align_d;
      bits_q     <= bits_d;
      pad_q      <= pad_d;
      done_q     <= done_d;
    end
  end

  // one result per file: after a result only a new file can produce another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !(push_o && !first_byte_i))
    else $error("second result without a new file");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !first_byte_i && done_q) |-> !push_o)
    else $error("result from a finished file");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !done_q && !first_byte_i && (phase_q == PHASE_SKIP)) |-> (skip_q != '0))
    else $error("skip phase entered with nothing to skip");

endmodule

@@ rtl/core/rwhp_queue.sv @@
module rwhp_queue #(
  parameter int unsigned Depth = rwhp_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rwhp_pkg::result_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rwhp_pkg::result_t entry_o
);
  import rwhp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t          mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

@@ rtl/core/rwhp_back.sv @@
module rwhp_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  rwhp_pkg::result_t                       entry_i,
  output logic                                    pop_o,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [rwhp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
  import rwhp_pkg::*;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  format_e                code;
  logic                   ok;
  logic                   load;

  assign load  = valid_i && (!out_valid_q || m_axis_tready);
  assign pop_o = load;
  assign ok    = (entry_i.status == STATUS_OK);

  always_comb begin
    if (entry_i.channels == 16'd1) begin
      code = (entry_i.block_align == 16'd2) ? FORMAT_MONO16 : FORMAT_MONO8;
    end else begin
      code = (entry_i.block_align == 16'd4) ? FORMAT_STEREO16 : FORMAT_STEREO8;
    end
  end

  // error results carry nothing but the status
  always_comb begin
    out_data_d        = '0;
    out_data_d[1:0]   = entry_i.status;
    if (ok) begin
      out_data_d[3:2]     = code;
      out_data_d[19:4]    = entry_i.compression;
      out_data_d[35:20]   = entry_i.channels;
      out_data_d[67:36]   = entry_i.sample_rate;
      out_data_d[99:68]   = entry_i.byte_rate;
      out_data_d[115:100] = entry_i.block_align;
      out_data_d[131:116] = entry_i.bits_per_sample;
      out_data_d[163:132] = entry_i.data_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q[1:0] != STATUS_OK)) |-> (out_data_q[OUT_TDATA_W-1:2] == '0))
    else $error("error result carries header fields");

endmodule

@@ tb/riff_wave_header_parser_tb.sv @@
module riff_wave_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwhp_pkg::*;

  localparam int ITEM_TARGET   = 1250;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int NUM_ROWS      = 25;

  typedef struct packed {
    status_e     status;
    format_e     fmt_code;
    logic [15:0] compression;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } wav_header_t;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       typed;
    status_e    status;
  } probe_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  riff_wave_header_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Header fragments with error results that can be read off directly.
  probe_row_t probe_rows [NUM_ROWS] = '{
    '{8'hFF, 1'b0, 1'b1, 1'b1, STATUS_NOT_RIFF},
    '{8'h52, 1'b1, 1'b0, 1'b0, STATUS_OK},
    '{8'h49, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h57, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h41, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h56, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h45, 1'b0, 1'b0, 1'b1, STATUS_NO_DATA},
    '{8'h52, 1'b1, 1'b0, 1'b0, STATUS_OK},
    '{8'h49, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h57, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h41, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h56, 1'b0, 1'b0, 1'b0, STATUS_OK},
    '{8'h00, 1'b0, 1'b1, 1'b1, STATUS_NOT_WAVE}
  };

  // parser state mirrored from the block
  phase_e      ph;
  logic [2:0]  fcnt;
  logic [31:0] fshift;
  logic [31:0] field_val;
  logic [31:0] riff_sz;
  logic [31:0] used_cnt;
  logic [31:0] chunk_len;
  logic [31:0] skip_cnt;
  logic [15:0] w_tag;
  logic [15:0] w_ch;
  logic [31:0] w_rate;
  logic [31:0] w_brate;
  logic [15:0] w_align;
  logic [15:0] w_bits;
  logic        pad_due;
  logic        hdr_done;

  wav_header_t header_q [$];
  int          err_count;
  int          parsed_bytes;
  int          burst_left;
  int          ready_mode;
  int          ready_left;
  int          idle_cycles;
  logic        fixed_exp;
  status_e     fixed_status;

  function automatic void restart_parse();
    ph        = PHASE_RIFF;
    fcnt      = '0;
    fshift    = '0;
    field_val = '0;
    riff_sz   = '0;
    used_cnt  = START_COUNT;
    chunk_len = '0;
    skip_cnt  = '0;
    w_tag     = '0;
    w_ch      = '0;
    w_rate    = '0;
    w_brate   = '0;
    w_align   = '0;
    w_bits    = '0;
    pad_due   = 1'b0;
    hdr_done  = 1'b0;
  endfunction

  function automatic bit collect(input logic [7:0] b, input int need);
    fshift |= 32'(b) << (8 * fcnt[1:0]);
    fcnt++;
    if (fcnt < need) return 1'b0;
    field_val = fshift;
    fshift    = '0;
    fcnt      = '0;
    return 1'b1;
  endfunction

  // saturate rather than wrap
  function automatic void count_up(input logic [31:0] n);
    logic [32:0] sum;
    sum      = {1'b0, used_cnt} + {1'b0, n};
    used_cnt = sum[32] ? '1 : sum[31:0];
  endfunction

  function automatic int close_chunk();
    if (used_cnt >= riff_sz) return STATUS_NO_DATA;
    ph = PHASE_ID;
    return -1;
  endfunction

  function automatic int finish_body();
    if (pad_due) begin
      ph = PHASE_PAD;
      return -1;
    end
    return close_chunk();
  endfunction

  function automatic int start_skip(input logic [31:0] n);
    skip_cnt = n;
    if (n == 0) return finish_body();
    ph = PHASE_SKIP;
    return -1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic first, input logic last,
                                     output bit produced, output wav_header_t hdr);
    int          res;
    logic [31:0] extra;
    res      = -1;
    produced = 1'b0;
    hdr      = '0;
    if (first) restart_parse();
    if (hdr_done) return;
    case (ph)
      PHASE_RIFF: begin
        if (collect(b, 4)) begin
          if (field_val != TAG_RIFF) res = STATUS_NOT_RIFF;
          else ph = PHASE_RSIZE;
        end
      end
      PHASE_RSIZE: begin
        if (collect(b, 4)) begin
          riff_sz = field_val;
          ph      = PHASE_WAVE;
        end
      end
      PHASE_WAVE: begin
        if (collect(b, 4)) begin
          if (field_val != TAG_WAVE) res = STATUS_NOT_WAVE;
          else res = close_chunk();
        end
      end
      PHASE_ID: begin
        if (collect(b, 4)) begin
          count_up(4);
          // only three id bytes decide a format chunk
          if (field_val[23:0] == TAG_FMT3) ph = PHASE_FSIZE;
          else if (field_val == TAG_DATA) ph = PHASE_DSIZE;
          else ph = PHASE_OSIZE;
        end
      end
      PHASE_FSIZE, PHASE_DSIZE, PHASE_OSIZE: begin
        if (collect(b, 4)) begin
          count_up(4);
          chunk_len = field_val;
          pad_due   = field_val[0];
          if (ph == PHASE_DSIZE) begin
            res = STATUS_OK;
          end else if (ph == PHASE_FSIZE) begin
            ph = PHASE_TAG;
          end else begin
            count_up(field_val);
            res = start_skip(field_val);
          end
        end
      end
      PHASE_TAG: begin
        if (collect(b, 2)) begin
          w_tag = field_val[15:0];
          ph    = PHASE_CH;
        end
      end
      PHASE_CH: begin
        if (collect(b, 2)) begin
          w_ch = field_val[15:0];
          ph   = PHASE_RATE;
        end
      end
      PHASE_RATE: begin
        if (collect(b, 4)) begin
          w_rate = field_val;
          ph     = PHASE_BRATE;
        end
      end
      PHASE_BRATE: begin
        if (collect(b, 4)) begin
          w_brate = field_val;
          ph      = PHASE_ALIGN;
        end
      end
      PHASE_ALIGN: begin
        if (collect(b, 2)) begin
          w_align = field_val[15:0];
          ph      = PHASE_BITS;
        end
      end
      PHASE_BITS: begin
        if (collect(b, 2)) begin
          extra  = (chunk_len > FMT_BODY) ? chunk_len - FMT_BODY : '0;
          w_bits = field_val[15:0];
          count_up(FMT_BODY);
          count_up(extra);
          res = start_skip(extra);
        end
      end
      PHASE_SKIP: begin
        skip_cnt--;
        if (skip_cnt == 0) res = finish_body();
      end
      PHASE_PAD: begin
        count_up(1);
        pad_due = 1'b0;
        res     = close_chunk();
      end
      default: res = STATUS_NO_DATA;
    endcase

    // the file ran out before a result
    if (res < 0 && last) begin
      if (ph == PHASE_RIFF) res = STATUS_NOT_RIFF;
      else if (ph <= PHASE_WAVE) res = STATUS_NOT_WAVE;
      else res = STATUS_NO_DATA;
    end
    if (res < 0) return;

    hdr_done   = 1'b1;
    produced   = 1'b1;
    hdr.status = status_e'(res);
    if (hdr.status == STATUS_OK) begin
      if (w_ch == 16'd1) hdr.fmt_code = (w_align == 16'd2) ? FORMAT_MONO16 : FORMAT_MONO8;
      else hdr.fmt_code = (w_align == 16'd4) ? FORMAT_STEREO16 : FORMAT_STEREO8;
      hdr.compression     = w_tag;
      hdr.channels        = w_ch;
      hdr.sample_rate     = w_rate;
      hdr.byte_rate       = w_brate;
      hdr.block_align     = w_align;
      hdr.bits_per_sample = w_bits;
      hdr.data_size       = chunk_len;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  function automatic void put_le(ref logic [7:0] img[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) img.push_back(v[8*i +: 8]);
  endfunction

  // Build one file: mostly well-formed headers with random content, some noise,
  // corrupted tags, huge chunks and files broken off part-way.
  task automatic build_wav(ref logic [7:0] img[$], output int last_at);
    int          n_chunks;
    logic [31:0] chunk_sz;
    logic [31:0] body_len;
    logic [31:0] v;
    bit          cut;
    img.delete();
    cut     = 1'b0;
    last_at = -1;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 14)) img.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 1) last_at = img.size() - 1;
      return;
    end

    v = ($urandom_range(0, 24) == 0) ? 32'h1 << $urandom_range(0, 31) : '0;
    put_le(img, TAG_RIFF ^ v, 4);
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 48);
      2:       v = '1;
      default: v = $urandom_range(60, 4000);
    endcase
    put_le(img, v, 4);
    v = ($urandom_range(0, 24) == 0) ? 32'h1 << $urandom_range(0, 31) : '0;
    put_le(img, TAG_WAVE ^ v, 4);

    n_chunks = $urandom_range(0, 3);
    for (int c = 0; c < n_chunks && !cut; c++) begin
      if ($urandom_range(0, 1) == 1) begin
        put_le(img, {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h20, TAG_FMT3}, 4);
        case ($urandom_range(0, 7))
          0:       chunk_sz = $urandom_range(0, 15);
          1:       chunk_sz = $urandom_range(17, 23);
          2:       chunk_sz = $urandom;
          default: chunk_sz = FMT_BODY;
        endcase
        put_le(img, chunk_sz, 4);
        put_le(img, ($urandom_range(0, 3) == 0) ? $urandom : 32'd1, 2);
        case ($urandom_range(0, 3))
          0:       v = $urandom;
          1:       v = 32'd1;
          default: v = 32'd2;
        endcase
        put_le(img, v, 2);
        put_le(img, $urandom, 4);
        put_le(img, $urandom, 4);
        case ($urandom_range(0, 3))
          0:       v = $urandom;
          1:       v = 32'd1;
          2:       v = 32'd2;
          default: v = 32'd4;
        endcase
        put_le(img, v, 2);
        case ($urandom_range(0, 2))
          0:       v = $urandom;
          1:       v = 32'd8;
          default: v = 32'd16;
        endcase
        put_le(img, v, 2);
        body_len = (chunk_sz > FMT_BODY) ? chunk_sz - FMT_BODY : '0;
      end else begin
        put_le(img, $urandom, 4);
        chunk_sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7);
        put_le(img, chunk_sz, 4);
        body_len = chunk_sz;
      end
      if (body_len > 64) begin
        // too long to walk through: end the file before the skipped bytes are all sent
        repeat ($urandom_range(0, 8)) img.push_back(8'($urandom));
        cut = 1'b1;
      end else begin
        repeat (body_len) img.push_back(8'($urandom));
        if (chunk_sz[0]) img.push_back(8'($urandom));
      end
    end

    if (!cut && $urandom_range(0, 7) != 0) begin
      put_le(img, TAG_DATA, 4);
      case ($urandom_range(0, 3))
        0:       v = $urandom;
        1:       v = '0;
        2:       v = '1;
        default: v = $urandom_range(1, 2000);
      endcase
      put_le(img, v, 4);
      // sample bytes, ignored by the parser
      repeat ($urandom_range(0, 3)) img.push_back(8'($urandom));
    end

    if (!cut && $urandom_range(0, 7) == 0) begin
      last_at = $urandom_range(0, img.size() - 1);
      img     = img[0:last_at];
    end else if (cut || $urandom_range(0, 3) != 0) begin
      last_at = img.size() - 1;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic first, input logic last,
                           input logic typed, input status_e status);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = first;
    s_axis_tlast  = last;
    fixed_exp     = typed;
    fixed_status  = status;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // hold the input until every expected header has come out
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (header_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    logic [7:0] img [$];
    int         last_at;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    fixed_exp     = 1'b0;
    fixed_status  = STATUS_OK;
    restart_parse();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (probe_rows[i]) begin
      send_item(probe_rows[i].b, probe_rows[i].first, probe_rows[i].last,
                probe_rows[i].typed, probe_rows[i].status);
    end
    drain_results();

    while (parsed_bytes < ITEM_TARGET) begin
      build_wav(img, last_at);
      foreach (img[i]) send_item(img[i], i == 0, i == last_at, 1'b0, STATUS_OK);
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(16, 96);
    end
    ready_left--;
    case (ready_mode)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = 1'($urandom_range(0, 1));
      2:       m_axis_tready = ready_left[2];
      default: m_axis_tready = ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    wav_header_t hdr;
    bit          produced;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      parsed_bytes++;
      parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, produced, hdr);
      if (fixed_exp) begin
        hdr        = '0;
        hdr.status = fixed_status;
      end
      if (fixed_exp || produced) header_q.push_back(hdr);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (header_q.size() == 0) begin
        $error("header result 0x%0h arrived with none expected", m_axis_tdata);
        err_count++;
      end else begin
        hdr = header_q.pop_front();
        check_field("status", hdr.status, m_axis_tdata[1:0]);
        check_field("format_code", hdr.fmt_code, m_axis_tdata[3:2]);
        check_field("compression", hdr.compression, m_axis_tdata[19:4]);
        check_field("channels", hdr.channels, m_axis_tdata[35:20]);
        check_field("sample_rate", hdr.sample_rate, m_axis_tdata[67:36]);
        check_field("byte_rate", hdr.byte_rate, m_axis_tdata[99:68]);
        check_field("block_align", hdr.block_align, m_axis_tdata[115:100]);
        check_field("bits_per_sample", hdr.bits_per_sample, m_axis_tdata[131:116]);
        check_field("data_size", hdr.data_size, m_axis_tdata[163:132]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

@@ sim.f @@
rtl/core/rwhp_pkg.sv
rtl/core/rwhp_front.sv
rtl/core/rwhp_queue.sv
rtl/core/rwhp_back.sv
rtl/core/riff_wave_header_parser.sv
tb/riff_wave_header_parser_tb.sv
